// ===== sv/pid_bitmap_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// PID bitmap allocator assertion macros
// Same-cycle implication and next-cycle property checks, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef PID_BITMAP_ALLOCATOR_MACROS_SVH
`define PID_BITMAP_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define PBA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pid allocator check failed");
`define PBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pid allocator check failed");
`else
`define PBA_ASSERT_IMPL(label, ante, cons)
`define PBA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/pba_pkg.sv =====
// ----------------------------------------------------------------------------
// PID bitmap allocator package
// Field widths, codes, controller states and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int ID_W = 16;
  localparam int XW = ID_W + 1;
  localparam int CFG_IDX_W = 8;

  localparam logic [ID_W-1:0] RESET_MIN_ID = 16'd300;
  localparam logic [ID_W-1:0] RESET_MAX_ID = 16'd5000;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_ID = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ID = 8'd1;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic [1:0] STATUS_ALLOCATED = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_RELEASED = 2'd2;
  localparam logic [1:0] STATUS_IGNORED = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clr_en;
    logic load;
    logic setup;
    logic scan_en;
    logic fin_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hit;
    logic exhausted;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== sv/pba_ctrl.sv =====
// ----------------------------------------------------------------------------
// PID bitmap allocator controller
// Sequences the clearing pass, request setup, word scan and result write-back.
// ----------------------------------------------------------------------------
module pba_ctrl
  import pba_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.hit || sts.exhausted) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
      end
      ST_FINISH: begin
        cmd.fin_en = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== sv/pba_datapath.sv =====
// ----------------------------------------------------------------------------
// PID bitmap allocator datapath
// Bitmap memory, configuration registers, word scanner and result register.
// ----------------------------------------------------------------------------
module pba_datapath
  import pba_pkg::*;
#(
  parameter int MAP_BITS = 8192,
  parameter int WORD_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            cmd,
  output ctrl_sts_t            sts,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ID_W-1:0]      cfg_data,
  input  logic                 in_func,
  input  logic [ID_W-1:0]      in_release_id,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ID_W-1:0]      out_granted_id,
  output logic [1:0]           out_status
);

  localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNT_W = $clog2(MAP_BITS + 1);
  localparam int BASE_W = $clog2(MAP_BITS + WORD_BITS + 1);

  logic [WORD_BITS-1:0] mem [MAP_WORDS];

  logic [ID_W-1:0] min_id;
  logic [ID_W-1:0] max_id;
  logic [ID_W-1:0] last_granted;
  logic [XW-1:0]   hi;

  logic            op_func;
  logic [ID_W-1:0] op_rid;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] off0;
  logic [CNT_W-1:0] rel_off;
  logic             rel_ok;

  logic [AW-1:0]     iss_addr;
  logic [BASE_W-1:0] iss_base;
  logic              dat_valid;
  logic [AW-1:0]     dat_addr;
  logic [BASE_W-1:0] dat_base;
  logic [WORD_BITS-1:0] rd_data;

  logic                 sel_found;
  logic [AW-1:0]        sel_addr;
  logic [WORD_BITS-1:0] sel_word;
  logic [CNT_W-1:0]     sel_off;
  logic                 rec_valid;
  logic [AW-1:0]        rec_addr;
  logic [WORD_BITS-1:0] rec_word;
  logic [CNT_W-1:0]     rec_off;

  logic [AW-1:0] clr_addr;

  logic [XW-1:0] cap;
  logic [XW-1:0] min_x;
  logic [XW-1:0] cand;
  logic [XW-1:0] rid_x;
  logic          empty;

  logic [BASE_W-1:0]    bit_off [WORD_BITS];
  logic [WORD_BITS-1:0] a_vec;
  logic [WORD_BITS-1:0] b_vec;
  logic [WORD_BITS-1:0] m_vec;
  logic [WORD_BITS-1:0] a_iso;
  logic [WORD_BITS-1:0] b_iso;
  logic [BASE_W-1:0]    a_off;
  logic [BASE_W-1:0]    b_off;

  logic       rd_en;
  logic       hit;
  logic       grant_ok;
  logic       wr_en;
  logic [AW-1:0] wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [CNT_W-1:0] fin_off;
  logic [XW-1:0]    grant_x;

  assign min_x = XW'(min_id);
  assign cap = min_x + XW'(MAP_BITS - 1);
  assign cand = XW'(last_granted) + XW'(1);
  assign rid_x = XW'(op_rid);
  assign empty = hi < min_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_id <= RESET_MIN_ID;
      max_id <= RESET_MAX_ID;
    end else if (cfg_valid) begin
      if (cfg_index == REG_MIN_ID) min_id <= cfg_data;
      if (cfg_index == REG_MAX_ID) max_id <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    hi <= (XW'(max_id) < cap) ? XW'(max_id) : cap;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_func <= in_func;
      op_rid <= in_release_id;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      count <= empty ? '0 : CNT_W'(hi - min_x + XW'(1));
      off0 <= (cand < min_x || cand > hi) ? '0 : CNT_W'(cand - min_x);
      rel_off <= CNT_W'(rid_x - min_x);
      rel_ok <= !empty && rid_x >= min_x && rid_x <= hi;
      if (op_func == FUNC_ALLOC) begin
        lim <= empty ? '0 : CNT_W'(hi - min_x + XW'(1));
      end else begin
        lim <= (!empty && rid_x >= min_x && rid_x <= hi) ? CNT_W'(hi - min_x + XW'(1)) : '0;
      end
    end
  end

  always_comb begin
    a_vec = '0;
    b_vec = '0;
    m_vec = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      bit_off[j] = dat_base + BASE_W'(j);
      a_vec[j] = !rd_data[j] && bit_off[j] < BASE_W'(count) && bit_off[j] >= BASE_W'(off0);
      b_vec[j] = !rd_data[j] && bit_off[j] < BASE_W'(count) && bit_off[j] < BASE_W'(off0);
      m_vec[j] = bit_off[j] == BASE_W'(rel_off);
    end
    a_iso = a_vec & (~a_vec + WORD_BITS'(1));
    b_iso = b_vec & (~b_vec + WORD_BITS'(1));
    a_off = '0;
    b_off = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      a_off = a_off | (a_iso[j] ? bit_off[j] : '0);
      b_off = b_off | (b_iso[j] ? bit_off[j] : '0);
    end
  end

  assign hit = cmd.scan_en && dat_valid &&
               ((op_func == FUNC_ALLOC) ? |a_vec : |m_vec);
  assign rd_en = cmd.scan_en && !hit && iss_base < BASE_W'(lim);

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      iss_addr <= '0;
      iss_base <= '0;
    end else if (rd_en) begin
      iss_addr <= iss_addr + AW'(1);
      iss_base <= iss_base + BASE_W'(WORD_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.setup) begin
      dat_valid <= 1'b0;
    end else begin
      dat_valid <= rd_en;
    end
    if (rd_en) begin
      dat_addr <= iss_addr;
      dat_base <= iss_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.setup) begin
      sel_found <= 1'b0;
      rec_valid <= 1'b0;
    end else if (cmd.scan_en && dat_valid) begin
      if (hit) sel_found <= 1'b1;
      if (op_func == FUNC_ALLOC && !(|a_vec) && |b_vec && !rec_valid) rec_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      sel_addr <= dat_addr;
      sel_off <= CNT_W'(a_off);
      sel_word <= (op_func == FUNC_ALLOC) ? (rd_data | a_iso) : (rd_data & ~m_vec);
    end
    if (cmd.scan_en && dat_valid && op_func == FUNC_ALLOC && !(|a_vec) && |b_vec &&
        !rec_valid) begin
      rec_addr <= dat_addr;
      rec_off <= CNT_W'(b_off);
      rec_word <= rd_data | b_iso;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_en) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign grant_ok = op_func == FUNC_ALLOC && (sel_found || rec_valid);
  assign fin_off = sel_found ? sel_off : rec_off;
  assign grant_x = min_x + XW'(fin_off);

  always_comb begin
    wr_en = 1'b0;
    wr_addr = sel_found ? sel_addr : rec_addr;
    wr_data = sel_found ? sel_word : rec_word;
    if (cmd.clr_en) begin
      wr_en = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (cmd.fin_en) begin
      wr_en = grant_ok || (op_func == FUNC_RELEASE && rel_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[iss_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_granted <= RESET_MIN_ID - ID_W'(1);
    end else if (cmd.fin_en && grant_ok) begin
      last_granted <= grant_x[ID_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_en) begin
      if (op_func == FUNC_ALLOC) begin
        out_granted_id <= grant_ok ? grant_x[ID_W-1:0] : '0;
        out_status <= grant_ok ? STATUS_ALLOCATED : STATUS_FULL;
      end else begin
        out_granted_id <= '0;
        out_status <= rel_ok ? STATUS_RELEASED : STATUS_IGNORED;
      end
    end
  end

  always_comb begin
    sts.clr_last = clr_addr == AW'(MAP_WORDS - 1);
    sts.hit = hit;
    sts.exhausted = cmd.scan_en && !dat_valid && !(iss_base < BASE_W'(lim));
    sts.out_free = !out_valid || out_ready;
  end

endmodule

// ===== sv/pid_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// PID bitmap allocator
// Next-fit process-ID allocator over a word-organized bitmap memory.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel: tuser selects allocate or release,
// tdata carries the ID to release. Every request gives exactly one result word
// on m_axis: tdata holds the granted ID, tuser the status code.
// The cfg channel writes min_id (index 0) and max_id (index 1); the user must
// write them only while idle, which the block itself does not enforce. The
// channel is always ready, and other indexes are dropped.
// One request at a time: accept, a setup step, then a scan that reads one
// bitmap word per cycle from the lowest word of the range through the single
// memory read port, then a finish step that writes the word back and loads
// the result. An allocate stops at the word holding the first free ID after
// the cursor; when there is none it reads all W words of the usable range
// (W is 1024 for a full range at default size, 588 for the reset range). A
// release reads up to the word of its ID; a release out of range or any
// request on an empty range reads no words. The next request is accepted
// from the idle state that follows finish.
// After reset a clearing pass writes zero to every bitmap word, one per cycle
// (MAP_BITS / WORD_BITS words, 1024 at default size); no request is accepted
// until it ends. A stalled result holds in the output register; the next
// request may be accepted and worked on, and waits at finish until the
// result register is free.
// ----------------------------------------------------------------------------
module pid_bitmap_allocator
  import pba_pkg::*;
#(
  parameter int MAP_BITS = 8192,
  parameter int WORD_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,   // release_id
  input  logic [0:0]           s_axis_tuser,   // func
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,   // granted_id
  output logic [1:0]           m_axis_tuser,   // status
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  `include "pid_bitmap_allocator_macros.svh"

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  pba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pba_datapath #(
    .MAP_BITS  (MAP_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_func        (s_axis_tuser[0]),
    .in_release_id  (s_axis_tdata),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_granted_id (m_axis_tdata),
    .out_status     (m_axis_tuser)
  );

  `PBA_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `PBA_ASSERT_NEXT(a_finish_loads, cmd.fin_en, m_axis_tvalid)
  `PBA_ASSERT_IMPL(a_no_grant_zero, m_axis_tvalid && (m_axis_tuser != STATUS_ALLOCATED), m_axis_tdata == 16'd0)
  `PBA_ASSERT_IMPL(a_clear_blocks, cmd.clr_en, !s_axis_tready)

endmodule

// ===== dv/tb_pid_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// PID bitmap allocator testbench
// Sends allocate and release words over the request stream and programs the
// ID range between runs of traffic. Every reply word is compared with the
// output of an in-bench next-fit model kept in step at each accepted request.
// Directed cases cover the default range, a small range that fills up, an
// empty range, the capacity limit and the topmost ID. Random runs follow
// over many ranges, with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_pid_bitmap_allocator
  import pba_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_BITS = 8192;
  localparam int WORD_BITS = 8;
  localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int STALL_LIMIT = 20000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd2;

  typedef struct {
    logic [ID_W-1:0] id;
    logic [1:0]      status;
  } reply_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata = '0;   // release_id
  logic [0:0]           s_axis_tuser = '0;   // func
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;        // granted_id
  logic [1:0]           m_axis_tuser;        // status
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  logic [WORD_BITS-1:0] map_words [MAP_WORDS];
  logic [ID_W-1:0]      cur_min;
  logic [ID_W-1:0]      cur_max;
  logic [ID_W-1:0]      cursor;

  reply_t      owed_replies[$];
  int unsigned live_ids[$];
  int          mismatch_count = 0;
  int          send_idle_pct = 23;
  int          ready_idle_pct = 23;
  int          stall_cycles = 0;

  pid_bitmap_allocator #(
    .MAP_BITS (MAP_BITS),
    .WORD_BITS(WORD_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned usable_top();
    int unsigned cap;
    cap = cur_min + MAP_BITS - 1;
    return (cur_max < cap) ? cur_max : cap;
  endfunction

  task automatic next_fit_step(input logic fn, input logic [ID_W-1:0] rid,
                               output reply_t r);
    int unsigned hi;
    int unsigned cand;
    int unsigned off;
    int unsigned span;
    hi = usable_top();
    r.id = '0;
    if (fn == FUNC_ALLOC) begin
      r.status = STATUS_FULL;
      if (hi >= cur_min) begin
        span = hi - cur_min + 1;
        cand = 32'(cursor) + 1;
        if (cand < cur_min || cand > hi) cand = cur_min;
        for (int i = 0; i < span; i++) begin
          off = cand - cur_min;
          if (!map_words[off / WORD_BITS][off % WORD_BITS]) begin
            map_words[off / WORD_BITS][off % WORD_BITS] = 1'b1;
            cursor = cand[ID_W-1:0];
            r.id = cand[ID_W-1:0];
            r.status = STATUS_ALLOCATED;
            break;
          end
          cand = (cand == hi) ? 32'(cur_min) : cand + 1;
        end
      end
    end else if (hi >= cur_min && rid >= cur_min && rid <= hi) begin
      off = rid - cur_min;
      map_words[off / WORD_BITS][off % WORD_BITS] = 1'b0;
      r.status = STATUS_RELEASED;
    end else begin
      r.status = STATUS_IGNORED;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic send_req(input logic fn, input logic [ID_W-1:0] rid);
    reply_t r;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= fn;
    s_axis_tdata <= rid;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    next_fit_step(fn, rid, r);
    owed_replies.push_back(r);
    if (r.status == STATUS_ALLOCATED) live_ids.push_back(r.id);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_MIN_ID) cur_min = val;
    else if (idx == REG_MAX_ID) cur_max = val;
  endtask

  task automatic set_range(input logic [ID_W-1:0] lo, input logic [ID_W-1:0] hi);
    wait_idle();
    write_reg(REG_MIN_ID, lo);
    write_reg(REG_MAX_ID, hi);
    cfg_valid <= 1'b0;
    live_ids.delete();
  endtask

  task automatic run_phase(input int unsigned lo, input int unsigned hi, input int n);
    int unsigned top;
    int unsigned rid;
    int unsigned pick;
    int          k;
    set_range(lo[ID_W-1:0], hi[ID_W-1:0]);
    top = usable_top();
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      rid = $urandom_range(0, 65535);
      if (pick < 50) begin
        send_req(FUNC_ALLOC, rid[ID_W-1:0]);
      end else begin
        if (pick < 80 && live_ids.size() != 0) begin
          k = $urandom_range(0, live_ids.size() - 1);
          rid = live_ids[k];
          live_ids.delete(k);
        end else if (pick < 90 && top >= lo) begin
          rid = $urandom_range(top, lo);
        end
        send_req(FUNC_RELEASE, rid[ID_W-1:0]);
      end
    end
  endtask

  task automatic test_default_range();
    send_req(FUNC_ALLOC, 16'hffff);
    send_req(FUNC_ALLOC, 16'h0000);
    send_req(FUNC_RELEASE, 16'd300);
    send_req(FUNC_RELEASE, 16'd299);
    send_req(FUNC_RELEASE, 16'd5000);
    send_req(FUNC_RELEASE, 16'd5001);
    send_req(FUNC_RELEASE, 16'd0);
    send_req(FUNC_RELEASE, 16'hffff);
    send_req(FUNC_ALLOC, 16'h5555);
  endtask

  task automatic test_small_range_full();
    wait_idle();
    write_reg(REG_SPARE, 16'($urandom));
    write_reg(CFG_IDX_W'($urandom_range(3, 255)), 16'($urandom));
    set_range(16'd10, 16'd12);
    send_req(FUNC_ALLOC, 16'h0000);
    send_req(FUNC_ALLOC, 16'h0000);
    send_req(FUNC_ALLOC, 16'h0000);
    send_req(FUNC_RELEASE, 16'd11);
    send_req(FUNC_ALLOC, 16'h0000);
    send_req(FUNC_RELEASE, 16'd12);
    send_req(FUNC_RELEASE, 16'd12);
  endtask

  task automatic test_empty_range();
    set_range(16'd100, 16'd50);
    send_req(FUNC_ALLOC, 16'h0000);
    send_req(FUNC_RELEASE, 16'd75);
  endtask

  task automatic test_capacity_limit();
    set_range(16'd0, 16'hffff);
    send_req(FUNC_RELEASE, 16'd8191);
    send_req(FUNC_RELEASE, 16'd8192);
    send_req(FUNC_ALLOC, 16'h0000);
  endtask

  task automatic test_top_id();
    set_range(16'hffff, 16'hffff);
    send_req(FUNC_ALLOC, 16'h0000);
    send_req(FUNC_RELEASE, 16'hffff);
    send_req(FUNC_ALLOC, 16'h0000);
  endtask

  task automatic test_random_phases();
    int unsigned lo;
    int unsigned hi;
    run_phase(0, 65535, 30);
    run_phase(0, 0, 12);
    for (int p = 0; p < 10; p++) begin
      lo = $urandom_range(0, 65535);
      hi = lo + $urandom_range(0, 47);
      if (hi > 65535) hi = 65535;
      send_idle_pct = (p == 4) ? 0 : 23;
      ready_idle_pct = send_idle_pct;
      run_phase(lo, hi, 48);
    end
    send_idle_pct = 23;
    ready_idle_pct = 23;
    run_phase(300, 5000, 30);
    run_phase(65000, 65535, 20);
    lo = $urandom_range(1, 65535);
    run_phase(lo, $urandom_range(0, lo - 1), 10);
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= ready_idle_pct);
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (owed_replies.size() == 0) begin
        report_mismatch($sformatf("reply with none pending: id %0d status %0d",
                                  m_axis_tdata, m_axis_tuser));
      end else begin
        want = owed_replies.pop_front();
        if (m_axis_tdata !== want.id)
          report_mismatch($sformatf("granted_id got %0d want %0d", m_axis_tdata, want.id));
        if (m_axis_tuser !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", m_axis_tuser, want.status));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    foreach (map_words[i]) map_words[i] = '0;
    cur_min = RESET_MIN_ID;
    cur_max = RESET_MAX_ID;
    cursor = RESET_MIN_ID - 16'd1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_default_range();
    test_small_range_full();
    test_empty_range();
    test_capacity_limit();
    test_top_id();
    test_random_phases();
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && owed_replies.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
